### sv/wncs_pkg.sv
// shared types, codes and widths for the weighted nearest curve search
// no dependencies; imported by every module of the block
package wncs_pkg;

   // field widths
   localparam int RATE_W    = 24;
   localparam int WEIGHT_W  = 8;
   localparam int ACTION_W  = 2;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 11;
   localparam int CSR_IDX_W = 2;
   localparam int LANES     = 3;

   // datapath widths: difference, magnitude, square, weighted term, distance
   localparam int DIFF_W = RATE_W + 1;
   localparam int MAG_W  = RATE_W + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int TERM_W = SQ_W + WEIGHT_W;
   localparam int DIST_W = TERM_W + 2;

   // table depth default
   localparam int MAX_CURVES_DEF = 1024;

   // lane positions inside one curve
   localparam int LANE_SHORT = 0;
   localparam int LANE_MID   = 1;
   localparam int LANE_LONG  = 2;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_GAIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GAIN  = 2'd3;

   // register reset values
   localparam logic [WEIGHT_W-1:0] SHORT_GAIN_RST = 8'd40;
   localparam logic [WEIGHT_W-1:0] MID_GAIN_RST   = 8'd20;
   localparam logic [WEIGHT_W-1:0] LONG_GAIN_RST  = 8'd40;

   // one stored curve: lane 0 short, lane 1 mid, lane 2 long
   typedef logic [LANES-1:0][RATE_W-1:0] curve_type;

   // configuration seen by the distance pipeline
   typedef struct packed {
      logic                              fit_mode;
      logic [LANES-1:0][WEIGHT_W-1:0]    weight;
   } cfg_type;

   // marker that travels with each curve through the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

### sv/wncs_mem.sv
// curve table: one write port, one read port, registered read data
// depends on wncs_pkg for the curve type
module wncs_mem #(
   parameter int DEPTH  = wncs_pkg::MAX_CURVES_DEF,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  wncs_pkg::curve_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output wncs_pkg::curve_type rd_data_ff
);
   import wncs_pkg::*;

   curve_type mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### sv/wncs_dist.sv
// five-stage weighted distance pipeline: difference, magnitude, square or
// magnitude by fit mode, weight, sum; depends on wncs_pkg for types and widths
module wncs_dist (
   input  logic                clock,
   input  logic                reset,
   input  wncs_pkg::tag_type   in_tag,
   input  wncs_pkg::curve_type query,
   input  wncs_pkg::curve_type entry,
   input  wncs_pkg::cfg_type   cfg,
   output wncs_pkg::tag_type   out_tag,
   output logic [wncs_pkg::DIST_W-1:0] out_dist
);
   import wncs_pkg::*;

   localparam int STAGES = 5;

   tag_type                   tag_ff  [STAGES];
   logic signed [DIFF_W-1:0]  diff_ff [LANES];
   logic signed [DIFF_W-1:0]  diff_in [LANES];
   logic [MAG_W-1:0]          mag_ff  [LANES];
   logic [MAG_W-1:0]          mag_in  [LANES];
   logic [SQ_W-1:0]           sq_in   [LANES];
   logic [SQ_W-1:0]           term_ff [LANES];
   logic [SQ_W-1:0]           term_in [LANES];
   logic [TERM_W-1:0]         wterm_ff [LANES];
   logic [TERM_W-1:0]         wterm_in [LANES];
   logic [DIST_W-1:0]         sum_ff;
   logic [DIST_W-1:0]         sum_in;

   // per-lane arithmetic
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         diff_in[k]  = signed'({query[k][RATE_W-1], query[k]})
                     - signed'({entry[k][RATE_W-1], entry[k]});
         mag_in[k]   = diff_ff[k][DIFF_W-1] ? MAG_W'(-diff_ff[k]) : MAG_W'(diff_ff[k]);
         sq_in[k]    = mag_ff[k] * mag_ff[k];
         term_in[k]  = cfg.fit_mode ? sq_in[k] : SQ_W'(mag_ff[k]);
         wterm_in[k] = term_ff[k] * cfg.weight[k];
      end
      sum_in = DIST_W'(wterm_ff[LANE_SHORT]) + DIST_W'(wterm_ff[LANE_MID])
             + DIST_W'(wterm_ff[LANE_LONG]);
   end

   // tag shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            tag_ff[s] <= '0;
         end
      end else begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         diff_ff[k]  <= diff_in[k];
         mag_ff[k]   <= mag_in[k];
         term_ff[k]  <= term_in[k];
         wterm_ff[k] <= wterm_in[k];
      end
      sum_ff <= sum_in;
   end

   assign out_tag  = tag_ff[STAGES-1];
   assign out_dist = sum_ff;

endmodule

### sv/weighted_nearest_curve_search.sv
// top level of the weighted nearest curve search: control, registers, min search
// depends on wncs_pkg, wncs_mem and wncs_dist
//
// The response to a clear or append transaction is ready the cycle after
// acceptance. A query streams the stored curves out of the single-port-read
// table one per cycle through a five-stage distance pipeline. One transaction
// is in work at a time; a new request is taken in the same cycle that the
// previous response is taken. The table needs no clearing after reset.
module weighted_nearest_curve_search #(
   parameter int MAX_CURVES = wncs_pkg::MAX_CURVES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wncs_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [wncs_pkg::RATE_W-1:0]    req_short_rate,
   input  logic signed [wncs_pkg::RATE_W-1:0]    req_mid_rate,
   input  logic signed [wncs_pkg::RATE_W-1:0]    req_long_rate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wncs_pkg::STATUS_W-1:0]         rsp_status,
   output logic [wncs_pkg::INDEX_W-1:0]          rsp_best_index,
   input  logic                                  csr_we,
   input  logic [wncs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wncs_pkg::WEIGHT_W-1:0]         csr_wdata
);
   import wncs_pkg::*;

   localparam int IDX_W = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
   localparam int CNT_W = $clog2(MAX_CURVES + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_DONE} state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     count_dec;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]     last_addr_ff, last_addr_in;
   logic [CNT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]     best_ff, best_in;
   logic [DIST_W-1:0]    min_ff, min_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]   rsp_best_ff, rsp_best_in;
   curve_type            query_ff, query_in;
   curve_type            req_curve;
   curve_type            rd_data;
   cfg_type              cfg_ff;
   tag_type              rd_tag_ff;
   tag_type              dist_tag;
   logic [DIST_W-1:0]    scan_dist;
   logic                 req_fire;
   logic                 rsp_free;
   logic                 table_full;
   logic                 wr_en;
   logic                 rd_en;

   assign req_curve = {req_long_rate, req_mid_rate, req_short_rate};
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign table_full = (count_ff >= CNT_W'(MAX_CURVES));
   assign count_dec = count_ff - 1'b1;
   assign wr_en     = req_fire && (req_action == ACT_APPEND) && !table_full;
   assign rd_en     = (state_ff == S_SCAN);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fit_mode           <= 1'b0;
         cfg_ff.weight[LANE_SHORT] <= SHORT_GAIN_RST;
         cfg_ff.weight[LANE_MID]   <= MID_GAIN_RST;
         cfg_ff.weight[LANE_LONG]  <= LONG_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIT_MODE:   cfg_ff.fit_mode           <= csr_wdata[0];
            CSR_SHORT_GAIN: cfg_ff.weight[LANE_SHORT] <= csr_wdata;
            CSR_MID_GAIN:   cfg_ff.weight[LANE_MID]   <= csr_wdata;
            CSR_LONG_GAIN:  cfg_ff.weight[LANE_LONG]  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // curve table
   wncs_mem #(
      .DEPTH  (MAX_CURVES),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    (req_curve),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr_ff),
      .rd_data_ff (rd_data)
   );

   // distance pipeline
   wncs_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .query    (query_ff),
      .entry    (rd_data),
      .cfg      (cfg_ff),
      .out_tag  (dist_tag),
      .out_dist (scan_dist)
   );

   // next-state and response logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      last_addr_in  = last_addr_ff;
      cmp_idx_in    = cmp_idx_ff;
      best_in       = best_ff;
      min_in        = min_ff;
      query_in      = query_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_best_in   = rsp_best_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_best_in   = '0;
               case (req_action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        rd_addr_in   = '0;
                        last_addr_in = count_dec[IDX_W-1:0];
                        cmp_idx_in   = '0;
                        query_in     = req_curve;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == last_addr_ff) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_best_in   = INDEX_W'(best_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // running minimum, first strict minimum wins
      if (dist_tag.valid) begin
         if ((cmp_idx_ff == '0) || (scan_dist < min_ff)) begin
            min_in  = scan_dist;
            best_in = cmp_idx_ff + 1'b1;
         end
         cmp_idx_in = cmp_idx_ff + 1'b1;
         if (dist_tag.last) begin
            state_in = S_DONE;
         end
      end
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_tag_ff    <= '0;
         cmp_idx_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_best_ff     <= rsp_best_in;
         rd_tag_ff.valid <= rd_en;
         rd_tag_ff.last  <= rd_en && (rd_addr_ff == last_addr_ff);
         cmp_idx_ff      <= cmp_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      last_addr_ff  <= last_addr_in;
      best_ff       <= best_in;
      min_ff        <= min_in;
      query_ff      <= query_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_best_index = rsp_best_ff;

endmodule

### sv/wncs_checker.sv
// port-level checks for the weighted nearest curve search
// depends on wncs_pkg; bound to the top level below
module wncs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [wncs_pkg::ACTION_W-1:0]  req_action,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [wncs_pkg::STATUS_W-1:0]  rsp_status,
   input logic [wncs_pkg::INDEX_W-1:0]   rsp_best_index
);
   import wncs_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                   && $stable(rsp_best_index))
      else $error("response changed while stalled");

   // only a successful query carries an index
   a_index_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_EMPTY)
         |-> rsp_best_index == '0)
      else $error("index reported with error status");

   // a clear answers in the next cycle with ok and no index
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_CLEAR
         |=> rsp_valid && rsp_status == STATUS_OK && rsp_best_index == '0)
      else $error("clear response missing or wrong");

   // no request is taken while a stalled response blocks the output
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted over a stalled response");

endmodule

bind weighted_nearest_curve_search wncs_checker u_checker (.*);
